FILE: rtl/lztf_pkg.sv
// ----------------------------------------------------------------------------
// lztf_pkg: shared definitions for the two-flag lz decompressor
// Parse phases, error codes, register indexes and the per-request step record
// handed from the parser to the output pipeline.
// ----------------------------------------------------------------------------
package lztf_pkg;

  // history store geometry
  localparam int HIST_AW    = 12;
  localparam int HIST_DEPTH = 1 << HIST_AW;

  // header bytes skipped ahead of the compressed stream
  localparam int HEADER_BYTES = 16;
  localparam logic [31:0] HEADER_LEN = 32'(HEADER_BYTES);

  // configuration register indexes
  localparam logic CFG_COMPRESSED_LENGTH   = 1'b0;
  localparam logic CFG_UNCOMPRESSED_LENGTH = 1'b1;

  // request kinds carried in s_tuser
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_START,
    PH_FLAGS1,
    PH_FLAGS2,
    PH_DATA,
    PH_MATCH2,
    PH_COPY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BEFORE_START,
    ERR_CLIPPED,
    ERR_BUSY
  } err_t;

  // what one accepted request produces
  typedef struct packed {
    logic               emit;      // a decompressed byte comes out
    logic               from_lit;  // byte is the literal, not a history read
    logic               zero_src;  // copy source lies before the first output
    logic [7:0]         lit_byte;
    logic [HIST_AW-1:0] rd_addr;
    logic [HIST_AW-1:0] wr_addr;
    logic               pending;
    logic               done;
    err_t               err;
  } step_t;

endpackage

FILE: rtl/lztf_hist.sv
// ----------------------------------------------------------------------------
// lztf_hist: history store
// One write and one registered read per cycle; a read of the address written
// at the same edge returns the new byte.
// ----------------------------------------------------------------------------
module lztf_hist (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [lztf_pkg::HIST_AW-1:0] rd_addr,
  input  logic                        wr_en,
  input  logic [lztf_pkg::HIST_AW-1:0] wr_addr,
  input  logic [7:0]                  wr_data,
  output logic [7:0]                  rd_data
);

  logic [7:0] mem [lztf_pkg::HIST_DEPTH];

  // write port and read port with write-through bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: rtl/lztf_ctrl.sv
// ----------------------------------------------------------------------------
// lztf_ctrl: stream parser
// Holds the counters, flag words and copy state, decodes one request per
// accepted cycle and describes its result as a step record.
// ----------------------------------------------------------------------------
module lztf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                accept,
  input  logic                func,
  input  logic [7:0]          in_byte,
  output lztf_pkg::step_t     step
);

  localparam logic [12:0] SHORT_LEN_BIAS  = 13'd3;
  localparam logic [11:0] SHORT_DIST_BIAS = 12'd1;
  localparam logic [11:0] LONG_DIST_BIAS  = 12'd17;
  localparam logic [12:0] LONG_LEN_BIAS   = 13'd3;
  localparam logic [8:0]  FLAGS_EMPTY     = 9'd1;
  localparam logic [8:0]  FLAGS_MARK      = 9'h100;

  logic [31:0] comp_len;
  logic [31:0] uncomp_len;
  logic [31:0] out_count, out_count_next;
  logic [31:0] in_count, in_count_next;
  logic [8:0]  lit_flags, lit_flags_next;
  logic [8:0]  mk_flags, mk_flags_next;
  lztf_pkg::phase_t phase, phase_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [12:0] copy_rem, copy_rem_next;
  logic [11:0] copy_dist, copy_dist_next;

  lztf_pkg::phase_t ph0;
  lztf_pkg::phase_t ph1;
  logic [12:0] m_len;
  logic [11:0] m_dist;
  logic [31:0] room;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // leave header skip and resolve a step start into its first phase
  function automatic lztf_pkg::phase_t settle(
    input lztf_pkg::phase_t ph,
    input logic [31:0]      ic,
    input logic [31:0]      oc,
    input logic [31:0]      cl,
    input logic [31:0]      ul,
    input logic             lit_empty,
    input logic             mk_empty
  );
    lztf_pkg::phase_t p;
    p = ph;
    if ((p == lztf_pkg::PH_HEADER) && (ic >= lztf_pkg::HEADER_LEN)) begin
      p = lztf_pkg::PH_START;
    end
    if (p == lztf_pkg::PH_START) begin
      if ((ic >= cl) || (oc >= ul)) begin
        p = lztf_pkg::PH_DONE;
      end else if (lit_empty) begin
        p = lztf_pkg::PH_FLAGS1;
      end else if (mk_empty) begin
        p = lztf_pkg::PH_FLAGS2;
      end else begin
        p = lztf_pkg::PH_DATA;
      end
    end
    return p;
  endfunction

  // decode of the current request
  always_comb begin
    ph0 = settle(phase, in_count, out_count, comp_len, uncomp_len,
                 lit_flags == FLAGS_EMPTY, mk_flags == FLAGS_EMPTY);
    ph1             = ph0;
    out_count_next  = out_count;
    in_count_next   = in_count;
    lit_flags_next  = lit_flags;
    mk_flags_next   = mk_flags;
    first_byte_next = first_byte;
    copy_rem_next   = copy_rem;
    copy_dist_next  = copy_dist;
    m_len           = '0;
    m_dist          = '0;
    room            = '0;
    step            = '0;
    step.err        = lztf_pkg::ERR_NONE;
    step.rd_addr    = out_count[lztf_pkg::HIST_AW-1:0] - copy_dist;
    step.wr_addr    = out_count[lztf_pkg::HIST_AW-1:0];

    if (func == lztf_pkg::FUNC_TICK) begin
      // one copy byte per tick
      if ((ph0 == lztf_pkg::PH_COPY) && (copy_rem != '0)) begin
        step.emit     = 1'b1;
        step.zero_src = 32'(copy_dist) > out_count;
        if (step.zero_src) begin
          step.err = lztf_pkg::ERR_BEFORE_START;
        end
        out_count_next = sat_inc(out_count);
        copy_rem_next  = copy_rem - 13'd1;
        if (copy_rem == 13'd1) begin
          ph1 = lztf_pkg::PH_START;
        end
      end
    end else if (ph0 == lztf_pkg::PH_COPY) begin
      step.err = lztf_pkg::ERR_BUSY;
    end else if (!(ph0 inside {lztf_pkg::PH_DONE, lztf_pkg::PH_START})) begin
      in_count_next = sat_inc(in_count);
      case (ph0)
        lztf_pkg::PH_FLAGS1: begin
          lit_flags_next = {1'b0, in_byte} | FLAGS_MARK;
          ph1 = (mk_flags == FLAGS_EMPTY) ? lztf_pkg::PH_FLAGS2 : lztf_pkg::PH_DATA;
        end
        lztf_pkg::PH_FLAGS2: begin
          mk_flags_next = {1'b0, in_byte} | FLAGS_MARK;
          ph1 = lztf_pkg::PH_DATA;
        end
        lztf_pkg::PH_DATA: begin
          if (lit_flags[0]) begin
            first_byte_next = in_byte;
            ph1 = lztf_pkg::PH_MATCH2;
          end else begin
            step.emit      = 1'b1;
            step.from_lit  = 1'b1;
            step.lit_byte  = in_byte;
            out_count_next = sat_inc(out_count);
            lit_flags_next = lit_flags >> 1;
            ph1 = lztf_pkg::PH_START;
          end
        end
        lztf_pkg::PH_MATCH2: begin
          // short distance / long length, or long distance / short length
          if (mk_flags[0]) begin
            m_len  = 13'({first_byte[7:4], in_byte}) + SHORT_LEN_BIAS;
            m_dist = 12'(first_byte[3:0]) + SHORT_DIST_BIAS;
          end else begin
            m_dist = 12'({first_byte[7:5], in_byte}) + LONG_DIST_BIAS;
            m_len  = 13'(first_byte[4:0]) + LONG_LEN_BIAS;
          end
          mk_flags_next  = mk_flags >> 1;
          lit_flags_next = lit_flags >> 1;
          // clip the copy at the end of the output
          room = (out_count < uncomp_len) ? uncomp_len - out_count : '0;
          if (32'(m_len) > room) begin
            m_len    = room[12:0];
            step.err = lztf_pkg::ERR_CLIPPED;
          end
          copy_dist_next = m_dist;
          copy_rem_next  = m_len;
          ph1 = (m_len != '0) ? lztf_pkg::PH_COPY : lztf_pkg::PH_START;
        end
        default: begin
        end
      endcase
    end

    phase_next = settle(ph1, in_count_next, out_count_next, comp_len, uncomp_len,
                        lit_flags_next == FLAGS_EMPTY, mk_flags_next == FLAGS_EMPTY);
    step.pending = (phase_next == lztf_pkg::PH_COPY);
    step.done    = (phase_next == lztf_pkg::PH_DONE);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count  <= '0;
      in_count   <= '0;
      lit_flags  <= FLAGS_EMPTY;
      mk_flags   <= FLAGS_EMPTY;
      phase      <= lztf_pkg::PH_HEADER;
      first_byte <= '0;
      copy_rem   <= '0;
      copy_dist  <= '0;
    end else if (accept) begin
      out_count  <= out_count_next;
      in_count   <= in_count_next;
      lit_flags  <= lit_flags_next;
      mk_flags   <= mk_flags_next;
      phase      <= phase_next;
      first_byte <= first_byte_next;
      copy_rem   <= copy_rem_next;
      copy_dist  <= copy_dist_next;
    end
  end

  // length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_len   <= '0;
      uncomp_len <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lztf_pkg::CFG_COMPRESSED_LENGTH:   comp_len   <= cfg_wdata;
        lztf_pkg::CFG_UNCOMPRESSED_LENGTH: uncomp_len <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/lz_two_flag_decompressor.sv
// ----------------------------------------------------------------------------
// lz_two_flag_decompressor: byte-serial two-flag lz decompressor
// Skips the stream header, decodes literals and back-references and replays
// match bytes out of a 4096-byte history, one result per request.
// ----------------------------------------------------------------------------
// Usage
//   s_tuser selects the request: 0 delivers the compressed byte in s_tdata,
//   1 is a tick that emits the next pending copy byte. Every accepted request
//   gives exactly one result on the m_ side, in order.
//   Lengths are written over cfg_we / cfg_index / cfg_wdata while idle.
// Flow
//   One request per cycle sustained while m_tready stays high; an accepted
//   request loads the history read stage and then moves into the output
//   register, which drives m_tvalid.
//   The decode loop closes on the parser registers, so a tick may follow a
//   match byte or another tick immediately.
// Reset
//   rst clears counters, flags and the pipeline; the history store is not
//   cleared and needs no clearing pass.
// Stalls
//   While m_tready is low the output register holds, one more result waits in
//   the read stage and s_tready drops until the output moves.
// ----------------------------------------------------------------------------
module lz_two_flag_decompressor (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // compressed request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] copy_pending, [9] done_res,
                                 // [11:10] error_code, [15:12] zero
  output logic        m_tuser    // [0] out_valid
);

  lztf_pkg::step_t step;
  lztf_pkg::step_t s1;
  logic            s1_valid;
  logic            s1_move;
  logic            accept;
  logic [7:0]      rd_data;
  logic [7:0]      s1_byte;
  logic            wr_en;

  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  lztf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .func      (s_tuser),
    .in_byte   (s_tdata),
    .step      (step)
  );

  // result byte of the read stage
  always_comb begin
    if (!s1.emit) begin
      s1_byte = '0;
    end else if (s1.from_lit) begin
      s1_byte = s1.lit_byte;
    end else if (s1.zero_src) begin
      s1_byte = '0;
    end else begin
      s1_byte = rd_data;
    end
  end

  // every emitted byte enters history as it leaves the read stage
  assign wr_en = s1_move && s1.emit;

  lztf_hist u_hist (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (step.rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1.wr_addr),
    .wr_data (s1_byte),
    .rd_data (rd_data)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= step;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= {4'b0, s1.err, s1.done, s1.pending, s1_byte};
      m_tuser <= s1.emit;
    end
  end

endmodule

FILE: rtl/lztf_checker.sv
// ----------------------------------------------------------------------------
// lztf_checker: port-level checks for the decompressor
// Watches the result stream for held results and consistent status codes.
// ----------------------------------------------------------------------------
module lztf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // no byte means a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("byte set without out_valid");

  // a source before the start is only reported on an emitted copy byte
  a_err_emit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:10] == lztf_pkg::ERR_BEFORE_START)
      |-> m_tuser && m_tdata[7:0] == 8'd0)
    else $error("distance error without zero copy byte");

  // clipping and busy rejects never come with a byte
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[11:10] == lztf_pkg::ERR_NONE) ||
                            (m_tdata[11:10] == lztf_pkg::ERR_BEFORE_START))
    else $error("byte with clip or busy error");

  // reset empties the result stream
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result after reset");

endmodule

bind lz_two_flag_decompressor lztf_checker u_lztf_checker (.*);
